// ----- src/debounced_external_interrupt_lines_macros.svh -----
// assertion helpers included by the bank module
`ifndef DEBOUNCED_EXTERNAL_INTERRUPT_LINES_MACROS_SVH
`define DEBOUNCED_EXTERNAL_INTERRUPT_LINES_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define DEIL_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define DEIL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- src/deil_pkg.sv -----
package deil_pkg;

   localparam int LINE_W     = 4;
   localparam int PORT_W     = 4;
   localparam int TICKS_W    = 32;
   localparam int MASK_W     = 16;
   localparam int NOW_W      = 32;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      KIND_CONFIG   = 2'd0,
      KIND_DISABLE  = 2'd1,
      KIND_EVENT    = 2'd2,
      KIND_RESERVED = 2'd3
   } deil_kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_SHARE    = 2'd1,
      STATUS_DISPATCH = 2'd2
   } deil_status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CMD,
      FSM_EVAL,
      FSM_SCAN
   } deil_fsm_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic               cfg_we;
      logic               dis_we;
      logic               eval;
      logic               shift;
      logic [LINE_W-1:0]  line;
      logic [PORT_W-1:0]  port;
      logic [TICKS_W-1:0] ticks;
   } deil_ctl_type;

   // status gathered cell by cell along the chain
   typedef struct packed {
      logic              conflict;
      logic              hit;
      logic              more;
      logic [PORT_W-1:0] port;
   } deil_link_type;

endpackage

// ----- src/deil_cell.sv -----
module deil_cell
   import deil_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  deil_ctl_type          ctl,
   input  logic [TIME_WIDTH-1:0] now,
   input  logic                  pend,
   input  logic                  tok_prev,
   output logic                  tok_next,
   input  deil_link_type         link_in,
   output deil_link_type         link_out
);

   localparam logic [LINE_W-1:0] IDX = LINE_W'(INDEX);

   logic                  en_ff, en_in;
   logic [PORT_W-1:0]     port_ff, port_in;
   logic [TICKS_W-1:0]    thr_ff, thr_in;
   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic                  hit_ff, hit_in;
   logic                  tok_ff, tok_in;

   logic                  sel;
   logic                  clash;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  ripe;
   logic                  fire;
   logic                  mine;

   assign sel     = (ctl.line == IDX);
   assign clash   = en_ff && (port_ff != ctl.port);
   assign elapsed = now - time_ff;
   // compare both sides zero-extended to the sum of the two widths
   assign ripe    = {TICKS_W'(0), elapsed} >= {TIME_WIDTH'(0), thr_ff};
   assign fire    = en_ff && pend && ((thr_ff == '0) || ripe);
   assign mine    = tok_ff && hit_ff;

   always_comb begin
      en_in   = en_ff;
      port_in = port_ff;
      thr_in  = thr_ff;
      time_in = time_ff;
      hit_in  = hit_ff;
      tok_in  = tok_ff;
      if (ctl.cfg_we && sel && !clash) begin
         en_in   = 1'b1;
         port_in = ctl.port;
         thr_in  = ctl.ticks;
         time_in = now;
      end
      if (ctl.dis_we && sel && (port_ff == ctl.port)) begin
         en_in = 1'b0;
      end
      if (ctl.eval) begin
         hit_in = fire;
         if (fire && (thr_ff != '0)) begin
            time_in = now;
         end
      end
      if (ctl.shift) begin
         tok_in = tok_prev;
         if (tok_ff) begin
            hit_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff  <= 1'b0;
         hit_ff <= 1'b0;
         tok_ff <= 1'b0;
      end else begin
         en_ff  <= en_in;
         hit_ff <= hit_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff <= port_in;
      thr_ff  <= thr_in;
      time_ff <= time_in;
   end

   assign tok_next          = tok_ff;
   assign link_out.conflict = link_in.conflict | (sel & clash);
   assign link_out.hit      = link_in.hit | mine;
   assign link_out.more     = link_in.more | (hit_ff & ~tok_ff);
   assign link_out.port     = link_in.port | (port_ff & {PORT_W{mine}});

endmodule

// ----- src/debounced_external_interrupt_lines.sv -----
// Bank of NUM_LINES external interrupt lines, one cell per line in a chain. Each cell holds
// the line's enable, port, debounce threshold and a time stamp set on configure and on a
// debounced fire. A configure or disable word is accepted, then updates its cell and gives
// one status word. An event word is accepted, then every cell checks its pending bit and
// debounce window at once and stamps its time if it fires with a nonzero threshold, then a
// scan token walks the chain one cell per cycle and emits a dispatch word at every cell
// that fired, in ascending line order; the last dispatch carries tlast, and an event with no
// firing line gives no word. The token walk sets the event rate, and it only pauses while a
// dispatch waits on a full output register. A new word is taken only when the previous one
// is finished; the output register lets the last result wait for rsp_tready meanwhile.
// Time arithmetic wraps at TIME_WIDTH bits; kind 3 words are dropped with no result.
module debounced_external_interrupt_lines
   import deil_pkg::*;
#(
   parameter int NUM_LINES  = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // line[3:0], port[7:4], debounce_ticks[39:8], pending[55:40], levels[71:56], now[103:72]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status[1:0], fired_line[5:2], fired_port[9:6], fired_level[10], zero[15:11]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

`include "debounced_external_interrupt_lines_macros.svh"

   localparam logic [LINE_W-1:0] LAST_IDX = LINE_W'(NUM_LINES - 1);

   // controller state
   deil_fsm_type          state_ff, state_in;
   logic [LINE_W-1:0]     idx_ff, idx_in;

   // latched word
   deil_kind_type         kind_ff;
   logic [LINE_W-1:0]     line_ff;
   logic [PORT_W-1:0]     port_ff;
   logic [TICKS_W-1:0]    ticks_ff;
   logic [MASK_W-1:0]     pend_ff;
   logic [MASK_W-1:0]     lev_ff;
   logic [TIME_WIDTH-1:0] now_ff;
   logic [TIME_WIDTH+NOW_W-1:0] now_wide;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   deil_status_type       rsp_status_ff, rsp_status_in;
   logic [LINE_W-1:0]     rsp_line_ff, rsp_line_in;
   logic [PORT_W-1:0]     rsp_port_ff, rsp_port_in;
   logic                  rsp_level_ff, rsp_level_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_load;

   logic                  req_accept;
   logic                  out_free;
   logic                  tok_first;
   deil_ctl_type          ctl;
   deil_link_type         link [NUM_LINES+1];
   logic                  tok  [NUM_LINES+1];
   deil_link_type         link_out;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign now_wide   = {TIME_WIDTH'(0), req_tdata[103:72]};

   // ---------------------------------------------------------------- cell chain
   assign link[0] = '0;
   assign tok[0]  = tok_first;

   for (genvar g = 0; g < NUM_LINES; g++) begin : g_cell
      deil_cell #(
         .INDEX      (g),
         .TIME_WIDTH (TIME_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .now      (now_ff),
         .pend     (pend_ff[g]),
         .tok_prev (tok[g]),
         .tok_next (tok[g+1]),
         .link_in  (link[g]),
         .link_out (link[g+1])
      );
   end

   // token leaving the last cell is dropped
   assign link_out = link[NUM_LINES];

   // ---------------------------------------------------------------- controller
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      req_tready    = 1'b0;
      tok_first     = 1'b0;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_DONE;
      rsp_line_in   = '0;
      rsp_port_in   = '0;
      rsp_level_in  = 1'b0;
      rsp_last_in   = 1'b1;
      ctl.cfg_we    = 1'b0;
      ctl.dis_we    = 1'b0;
      ctl.eval      = 1'b0;
      ctl.shift     = 1'b0;
      ctl.line      = line_ff;
      ctl.port      = port_ff;
      ctl.ticks     = ticks_ff;

      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (deil_kind_type'(req_tuser))
                  KIND_CONFIG:  state_in = FSM_CMD;
                  KIND_DISABLE: state_in = FSM_CMD;
                  KIND_EVENT:   state_in = FSM_EVAL;
                  default:      state_in = FSM_IDLE;
               endcase
            end
         end
         FSM_CMD: begin
            // update the addressed cell only once the status word has a place
            if (out_free) begin
               ctl.cfg_we = (kind_ff == KIND_CONFIG);
               ctl.dis_we = (kind_ff == KIND_DISABLE);
               rsp_load   = 1'b1;
               if ((kind_ff == KIND_CONFIG) && link_out.conflict) begin
                  rsp_status_in = STATUS_SHARE;
               end
               state_in = FSM_IDLE;
            end
         end
         FSM_EVAL: begin
            // all cells decide at once, token enters cell zero
            ctl.eval  = 1'b1;
            ctl.shift = 1'b1;
            tok_first = 1'b1;
            idx_in    = '0;
            state_in  = FSM_SCAN;
         end
         FSM_SCAN: begin
            if (!link_out.hit || out_free) begin
               ctl.shift = 1'b1;
               if (link_out.hit) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STATUS_DISPATCH;
                  rsp_line_in   = idx_ff;
                  rsp_port_in   = link_out.port;
                  rsp_level_in  = lev_ff[idx_ff];
                  rsp_last_in   = !link_out.more;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= deil_kind_type'(req_tuser);
         line_ff  <= req_tdata[3:0];
         port_ff  <= req_tdata[7:4];
         ticks_ff <= req_tdata[39:8];
         pend_ff  <= req_tdata[55:40];
         lev_ff   <= req_tdata[71:56];
         now_ff   <= now_wide[TIME_WIDTH-1:0];
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_line_ff   <= rsp_line_in;
         rsp_port_ff   <= rsp_port_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_level_ff, rsp_port_ff, rsp_line_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   `DEIL_ASSERT_IMPLIES(a_hit_only_in_scan, link_out.hit, state_ff == FSM_SCAN)
   `DEIL_ASSERT_NEXT(a_cmd_gives_status, (state_ff == FSM_CMD) && out_free, rsp_tvalid && rsp_tlast && (rsp_tdata[1:0] != STATUS_DISPATCH))
   `DEIL_ASSERT_NEXT(a_word_leaves_idle, req_accept && (req_tuser != KIND_RESERVED), state_ff != FSM_IDLE)

endmodule

// ----- tb/debounced_external_interrupt_lines_tb.sv -----
module debounced_external_interrupt_lines_tb
   import deil_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_COUNT      = 16;
   // long receiver hold-off so the output register fills and req_tready drops
   localparam int HOLD_OFF_CYCLES = 150;
   // cycles with no word moving on either side before giving up
   localparam int STALL_LIMIT     = 4000;
   // an event walks the whole chain after its last dispatch
   localparam int DRAIN_CYCLES    = 2 * LINE_COUNT + 8;

   // one result word as the block emits it
   typedef struct packed {
      deil_status_type   status;
      logic [LINE_W-1:0] line;
      logic [PORT_W-1:0] port;
      logic              level;
      logic              last;
   } line_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // shadow copy of the line bank
   logic               shadow_enabled   [LINE_COUNT];
   logic [PORT_W-1:0]  shadow_port      [LINE_COUNT];
   logic [TICKS_W-1:0] shadow_threshold [LINE_COUNT];
   logic [NOW_W-1:0]   shadow_stamp     [LINE_COUNT];

   // words the block still owes, oldest first
   line_word_type    owed_words[$];
   line_word_type    head_word;
   int unsigned      mismatch_count = 0;
   int unsigned      quiet_cycles   = 0;
   logic [NOW_W-1:0] tick_now       = '0;
   bit               send_idling      = 1'b1;
   bit               take_idling      = 1'b1;
   bit               hold_off_request = 1'b0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   debounced_external_interrupt_lines #(
      .NUM_LINES (LINE_COUNT),
      .TIME_WIDTH(NOW_W)
   ) DUT (.*);

   // ---------------------------------------------------------------------------------------
   // line bank prediction: updates the shadow state and queues the words one input causes
   // ---------------------------------------------------------------------------------------
   function automatic void predict_line_words(input deil_kind_type kind,
         input logic [LINE_W-1:0] line, input logic [PORT_W-1:0] port,
         input logic [TICKS_W-1:0] ticks, input logic [MASK_W-1:0] pending,
         input logic [MASK_W-1:0] levels, input logic [NOW_W-1:0] now);
      line_word_type    word;
      logic [NOW_W-1:0] elapsed;
      int               fired;
      word  = '0;
      fired = 0;
      case (kind)
         KIND_CONFIG: begin
            // refused while the line is taken by another port
            if (shadow_enabled[line] && shadow_port[line] != port) begin
               word.status = STATUS_SHARE;
            end else begin
               word.status             = STATUS_DONE;
               shadow_enabled[line]    = 1'b1;
               shadow_port[line]       = port;
               shadow_threshold[line]  = ticks;
               shadow_stamp[line]      = now;
            end
            word.last = 1'b1;
            owed_words.push_back(word);
         end
         KIND_DISABLE: begin
            // only the owning port may disable
            if (shadow_port[line] == port)
               shadow_enabled[line] = 1'b0;
            word.status = STATUS_DONE;
            word.last   = 1'b1;
            owed_words.push_back(word);
         end
         KIND_EVENT: begin
            for (int i = 0; i < LINE_COUNT; i++) begin
               if (pending[i] && shadow_enabled[i]) begin
                  elapsed = now - shadow_stamp[i];
                  if (shadow_threshold[i] == '0 || elapsed >= shadow_threshold[i]) begin
                     // zero threshold fires without touching the stamp
                     if (shadow_threshold[i] != '0)
                        shadow_stamp[i] = now;
                     word.status = STATUS_DISPATCH;
                     word.line   = LINE_W'(i);
                     word.port   = shadow_port[i];
                     word.level  = levels[i];
                     word.last   = 1'b0;
                     owed_words.push_back(word);
                     fired++;
                  end
               end
            end
            if (fired > 0)
               owed_words[owed_words.size() - 1].last = 1'b1;
         end
         default: begin
            // reserved kind is dropped silently
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // sender: called at a falling edge, returns at a falling edge with req_tvalid low
   // ---------------------------------------------------------------------------------------
   task automatic send_word(input deil_kind_type kind, input logic [LINE_W-1:0] line,
         input logic [PORT_W-1:0] port, input logic [TICKS_W-1:0] ticks,
         input logic [MASK_W-1:0] pending, input logic [MASK_W-1:0] levels,
         input logic [NOW_W-1:0] now);
      if (send_idling && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 8)) @(negedge clock);
      req_tdata  = {now, levels, pending, ticks, port, line};
      req_tuser  = kind;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_line_words(kind, line, port, ticks, pending, levels, now);
      @(negedge clock);
      // a following send raises it again in this same step
      req_tvalid = 1'b0;
   endtask

   // unused fields carry random bits so every bit of tdata toggles
   task automatic send_config(input int line, input int port, input logic [TICKS_W-1:0] ticks);
      send_word(KIND_CONFIG, LINE_W'(line), PORT_W'(port), ticks, MASK_W'($urandom),
                MASK_W'($urandom), tick_now);
   endtask

   task automatic send_disable(input int line, input int port);
      send_word(KIND_DISABLE, LINE_W'(line), PORT_W'(port), $urandom, MASK_W'($urandom),
                MASK_W'($urandom), tick_now);
   endtask

   task automatic send_event(input logic [MASK_W-1:0] pending, input logic [MASK_W-1:0] levels);
      send_word(KIND_EVENT, LINE_W'($urandom_range(0, 15)), PORT_W'($urandom_range(0, 15)),
                $urandom, pending, levels, tick_now);
   endtask

   // mostly no debounce or a short window, now and then a huge one
   function automatic logic [TICKS_W-1:0] pick_threshold();
      int unsigned choice;
      choice = $urandom_range(0, 9);
      if (choice < 4)
         return '0;
      else if (choice < 9)
         return TICKS_W'($urandom_range(1, 48));
      else
         return $urandom;
   endfunction

   // ---------------------------------------------------------------------------------------
   // receiver: random stall bursts, plus one long hold-off on request
   // ---------------------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready       = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (take_idling && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // every accepted result word against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_words.size() == 0) begin
            report_mismatch("word with nothing owed", 32'(rsp_tdata), 32'(0));
         end else begin
            head_word = owed_words.pop_front();
            if (rsp_tdata[1:0] != head_word.status)
               report_mismatch("status", 32'(rsp_tdata[1:0]), 32'(head_word.status));
            if (rsp_tdata[5:2] != head_word.line)
               report_mismatch("fired_line", 32'(rsp_tdata[5:2]), 32'(head_word.line));
            if (rsp_tdata[9:6] != head_word.port)
               report_mismatch("fired_port", 32'(rsp_tdata[9:6]), 32'(head_word.port));
            if (rsp_tdata[10] != head_word.level)
               report_mismatch("fired_level", 32'(rsp_tdata[10]), 32'(head_word.level));
            if (rsp_tlast != head_word.last)
               report_mismatch("tlast", 32'(rsp_tlast), 32'(head_word.last));
         end
      end
   end

   // watchdog on cycles where no word moves on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("debounced_external_interrupt_lines_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------

   // nothing enabled after reset: a full event and a reserved word give nothing
   task automatic test_idle_bank();
      send_event(16'hFFFF, 16'hFFFF);
      send_word(KIND_RESERVED, LINE_W'($urandom_range(0, 15)), PORT_W'($urandom_range(0, 15)),
                $urandom, MASK_W'($urandom), MASK_W'($urandom), $urandom);
   endtask

   // port ownership: sharing refusal, same-port refresh, foreign disable
   task automatic test_port_sharing();
      tick_now = 32'd1000;
      send_config(0, 0, '0);
      send_config(15, 15, 32'hFFFF_FFFF);
      send_config(0, 5, 32'd7);
      send_config(0, 0, '0);
      send_disable(0, 7);
      // line 15 holds a maximal window and stays quiet
      send_event(16'h8001, 16'h0001);
   endtask

   // debounce window, including a window across the time wrap
   task automatic test_debounce_window();
      tick_now = 32'd100;
      send_config(3, 2, 32'd10);
      tick_now = 32'd105;
      send_event(16'h0008, 16'hFFFF);
      tick_now = 32'd110;
      send_event(16'h0008, 16'h0000);
      tick_now = 32'hFFFF_FFF8;
      send_config(4, 9, 32'd16);
      tick_now = 32'd8;
      send_event(16'h0010, 16'h0010);
      // matching disable removes line 3, line 4 is still inside its window
      send_disable(3, 2);
      send_event(16'h0018, 16'h0000);
   endtask

   // every line enabled without debounce, so an event dispatches all sixteen
   task automatic test_all_lines();
      for (int i = 0; i < LINE_COUNT; i++)
         send_config(i, shadow_enabled[i] ? int'(shadow_port[i]) : int'($urandom_range(0, 15)),
                     '0);
      send_event(16'hFFFF, 16'h0000);
      send_event(16'hFFFF, 16'hFFFF);
      send_event(16'hFFFF, MASK_W'($urandom));
   endtask

   // receiver holds off while full events keep coming, so the block backs up
   task automatic test_back_pressure();
      hold_off_request = 1'b1;
      for (int i = 0; i < 4; i++) begin
         send_event(16'hFFFF, MASK_W'($urandom));
         send_config(i, shadow_port[i], '0);
      end
   endtask

   // mixed traffic on a moving clock, ports biased toward the owning one
   task automatic test_random_traffic(input int unsigned count);
      int unsigned      sent;
      int unsigned      pick;
      int               line;
      int               port;
      logic [MASK_W-1:0] pending;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         line = $urandom_range(0, 15);
         port = ($urandom_range(0, 9) < 7) ? int'(shadow_port[line]) : $urandom_range(0, 15);
         if (pick < 35) begin
            send_config(line, port, pick_threshold());
            sent++;
         end else if (pick < 50) begin
            send_disable(line, port);
            sent++;
         end else if (pick < 96) begin
            // time moves in small steps, sometimes leaps and wraps
            if ($urandom_range(0, 24) == 0)
               tick_now += $urandom;
            else
               tick_now += $urandom_range(0, 24);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: pending = MASK_W'($urandom);
               5, 6, 7:       pending = 16'hFFFF;
               default:       pending = MASK_W'(1) << $urandom_range(0, 15);
            endcase
            send_event(pending, MASK_W'($urandom));
            sent++;
         end else begin
            // reserved kind, ignored by the block and not counted
            send_word(KIND_RESERVED, LINE_W'(line), PORT_W'(port), $urandom,
                      MASK_W'($urandom), MASK_W'($urandom), $urandom);
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < LINE_COUNT; i++) begin
         shadow_enabled[i]   = 1'b0;
         shadow_port[i]      = '0;
         shadow_threshold[i] = '0;
         shadow_stamp[i]     = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_idle_bank();
      test_port_sharing();
      test_debounce_window();
      test_all_lines();
      test_back_pressure();
      test_random_traffic(290);
      test_all_lines();

      // closing stretch with both sides streaming
      send_idling = 1'b0;
      take_idling = 1'b0;
      test_random_traffic(40);

      while (owed_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("debounced_external_interrupt_lines_tb OK");
      else
         $display("debounced_external_interrupt_lines_tb NOT OK");
      $finish;
   end

endmodule
